>>> rtl/lph_pkg.sv
// Shared types and codes for the linear probing hash table.
package lph_pkg;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_SET    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_ABSENT = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] key_id;
    logic [31:0] key_hash;
    logic [63:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] hit_value;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  mark;
    logic [31:0] key;
    logic [63:0] value;
  } entry_t;

endpackage

>>> rtl/linear_probe_hash_table_top.sv
// Linear probing hash table: request sequencer, slot memory and response register.
//
// Requests arrive on req/req_valid/req_ready, one word per lookup, set or remove.
// Each word yields exactly one response word on rsp/rsp_valid/rsp_ready.
// After reset the block sweeps the slot memory, marking every slot empty,
// one slot per cycle, while req_ready stays low.
// A request probes 1 to TABLE_SLOTS slots: accepting it starts the first slot
// read, then one slot is compared per cycle through the single memory read port
// while the sequencer is not holding for the response register. The response
// register is loaded in the last probe cycle; req_ready returns the next cycle.
// A response waiting in the output register does not block the next request;
// only if the previous response is still untaken when a probe finishes does
// the sequencer hold on that slot until rsp_ready frees the register.
// Probe runs stay short at the two-thirds load limit.
module linear_probe_hash_table_top
  import lph_pkg::*;
#(
  parameter int TABLE_SLOTS = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0] PROBE_MAX = CNT_W'(TABLE_SLOTS);
  localparam int FULL_AT_INT = (2 * TABLE_SLOTS + 2) / 3 - 1;
  localparam logic [CNT_W-1:0] FULL_AT = CNT_W'(FULL_AT_INT);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;

  logic [1:0]       state, state_next;
  logic [IDX_W-1:0] clr_idx, clr_idx_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] live_count, live_next;
  req_t             req_q;
  entry_t           rd_entry;
  entry_t           mem [TABLE_SLOTS];

  logic             we;
  logic [IDX_W-1:0] wa;
  entry_t           wd;
  logic [IDX_W-1:0] rd_addr;
  logic             rsp_load;
  rsp_t             rsp_d;
  logic             cur_empty, cur_hit, wrapped, out_free;

  assign req_ready = (state == S_IDLE);
  assign cur_empty = (rd_entry.mark == MARK_EMPTY);
  assign cur_hit   = (rd_entry.mark == MARK_LIVE) && (rd_entry.key == req_q.key_id);
  assign wrapped   = (cnt == PROBE_MAX);
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    state_next    = state;
    clr_idx_next  = clr_idx;
    pos_next      = pos;
    cnt_next      = cnt;
    live_next     = live_count;
    rsp_load      = 1'b0;
    rsp_d.status    = STATUS_ABSENT;
    rsp_d.hit_value = '0;
    we            = 1'b0;
    wa            = pos & IDX_MASK;
    wd            = '0;
    rd_addr       = pos & IDX_MASK;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_idx;
        if (clr_idx == IDX_LAST) begin
          state_next = S_IDLE;
        end else begin
          clr_idx_next = clr_idx + 1'b1;
        end
      end
      S_IDLE: begin
        rd_addr = req.key_hash[IDX_W-1:0] & IDX_MASK;
        if (req_valid) begin
          pos_next   = req.key_hash[IDX_W-1:0] & IDX_MASK;
          cnt_next   = CNT_W'(1);
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (cur_hit || cur_empty || wrapped) begin
          if (out_free) begin
            state_next = S_IDLE;
            rsp_load   = 1'b1;
            unique case (req_q.action)
              ACT_LOOKUP: begin
                if (cur_hit) begin
                  rsp_d.status    = STATUS_OK;
                  rsp_d.hit_value = rd_entry.value;
                end
              end
              ACT_SET: begin
                if (cur_hit) begin
                  we = 1'b1;
                  wd = '{mark: MARK_LIVE, key: req_q.key_id, value: req_q.new_value};
                  rsp_d.status = STATUS_OK;
                end else if (!cur_empty || live_count >= FULL_AT) begin
                  rsp_d.status = STATUS_FULL;
                end else begin
                  we = 1'b1;
                  wd = '{mark: MARK_LIVE, key: req_q.key_id, value: req_q.new_value};
                  live_next    = live_count + 1'b1;
                  rsp_d.status = STATUS_OK;
                end
              end
              ACT_REMOVE: begin
                if (cur_hit) begin
                  we = 1'b1;
                  wd = '{mark: MARK_TOMB, key: rd_entry.key, value: rd_entry.value};
                  if (live_count != '0) begin
                    live_next = live_count - 1'b1;
                  end
                  rsp_d.status = STATUS_OK;
                end
              end
              default: begin
                rsp_d.status = STATUS_ABSENT;
              end
            endcase
          end
        end else begin
          pos_next = pos + 1'b1;
          cnt_next = cnt + 1'b1;
          rd_addr  = (pos + 1'b1) & IDX_MASK;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      live_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_idx    <= clr_idx_next;
      live_count <= live_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    cnt <= cnt_next;
    if (req_valid && req_ready) begin
      req_q <= req;
    end
    if (rsp_load) begin
      rsp <= rsp_d;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_entry <= mem[rd_addr];
  end

`ifndef SYNTHESIS
  a_live_limit: assert property (@(posedge clk) disable iff (rst)
    live_count <= FULL_AT)
    else $error("live count above load limit");

  a_rsp_from_probe: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_PROBE))
    else $error("response raised outside probe");

  a_hit_only_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.hit_value != '0) |-> rsp.status == STATUS_OK)
    else $error("nonzero hit value without success");

  a_live_change: assert property (@(posedge clk) disable iff (rst)
    !$stable(live_count) |-> $past(state == S_PROBE))
    else $error("live count changed outside probe");
`endif

endmodule
